[rtl/core/scbd_pkg.sv]
`default_nettype none

package scbd_pkg;

    // Sizing of the local RAMs and the ROM windows
    localparam int RAM_ADDR_BITS         = 20;
    localparam int PROG_ROM_ADDR_BITS    = 19;
    localparam int SAMPLE_BANK_ADDR_BITS = 23;

    localparam int RAM_WORD_BITS = RAM_ADDR_BITS - 1;
    localparam int RAM_WORDS     = 1 << RAM_WORD_BITS;

    localparam logic [23:0] PROG_MASK =
        24'((33'(1) << PROG_ROM_ADDR_BITS) - 33'(1));
    localparam logic [23:0] BANK_MASK =
        24'((33'(1) << SAMPLE_BANK_ADDR_BITS) - 33'(1));
    localparam logic [23:0] BANK_BASE =
        24'(33'(1) << SAMPLE_BANK_ADDR_BITS);

    localparam logic [23:0] CTRL_ADDR     = 24'h400001;
    localparam int          CTRL_BANK_BIT = 4;

    // Access sizes
    localparam logic [1:0] SIZE_BYTE = 2'd0;
    localparam logic [1:0] SIZE_WORD = 2'd1;
    localparam logic [1:0] SIZE_LONG = 2'd2;
    localparam logic [1:0] SIZE_NONE = 2'd3;

    // Address bits 23:20
    localparam logic [3:0] SEL_RAM_ONE = 4'h0;
    localparam logic [3:0] SEL_MASTER  = 4'h1;
    localparam logic [3:0] SEL_RAM_TWO = 4'h2;
    localparam logic [3:0] SEL_SLAVE   = 4'h3;
    localparam logic [3:0] SEL_PROG    = 4'h6;

    // Target region codes
    localparam logic [2:0] REGION_UNMAPPED = 3'd0;
    localparam logic [2:0] REGION_RAM_ONE  = 3'd1;
    localparam logic [2:0] REGION_MASTER   = 3'd2;
    localparam logic [2:0] REGION_RAM_TWO  = 3'd3;
    localparam logic [2:0] REGION_SLAVE    = 3'd4;
    localparam logic [2:0] REGION_PROG     = 3'd5;
    localparam logic [2:0] REGION_SAMPLE   = 3'd6;
    localparam logic [2:0] REGION_CONTROL  = 3'd7;

    typedef struct packed {
        logic        opcode;
        logic [1:0]  access_size;
        logic [23:0] bus_address;
        logic [31:0] write_value;
    } t_in_item;

    typedef struct packed {
        logic [31:0] read_value;
        logic [2:0]  target_region;
        logic        ext_request;
        logic [23:0] ext_address;
        logic        ext_write;
        logic [1:0]  ext_size;
        logic [31:0] ext_data;
    } t_out_item;

endpackage

`default_nettype wire

[rtl/core/scbd_ram.sv]
`default_nettype none

module scbd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_en,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // read data holds while the port is not enabled
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[rtl/core/sound_cpu_bus_decoder.sv]
// Sound CPU bus decoder.
// Input channel (i_in_valid / o_in_stall / i_in_item): one bus access per item,
// read or write, byte, word or long. Output channel (o_out_valid / i_out_stall /
// o_out_item): one result item per access, in order.
// The two local RAMs sit in single-port synchronous RAMs of 16-bit words, so
// the sequencer touches one word per RAM access. Byte/word reads, word writes,
// external and unmapped accesses go from acceptance straight to S_FIN; byte
// writes (read-modify-write) pass through S_RMW and long reads or writes
// through S_LONG first. From S_FIN the result moves into the output register
// and the sequencer returns to S_IDLE, where the next item is taken.
// A new item is taken once the previous result is in the output register,
// even while that result still waits to be taken.
// After reset both RAMs are zeroed by a clearing pass over all 524288 words
// (one word of each RAM per cycle); the input stalls until it is done.
// The control byte resets to zero.
// When the receiver stalls, the result holds in the output register; a
// second finished item waits in the sequencer and the input stalls.
`default_nettype none

module sound_cpu_bus_decoder
    import scbd_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_stall,
    input  wire t_in_item  i_in_item,
    output logic           o_out_valid,
    input  wire logic      i_out_stall,
    output t_out_item      o_out_item
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_RMW,
        S_LONG,
        S_FIN
    } t_state;

    t_state    r_state;
    logic [RAM_WORD_BITS-1:0] r_clr;
    t_in_item  r_item;
    logic [15:0] r_hi;
    logic [7:0]  r_ctrl;
    logic        r_out_valid;
    t_out_item   r_out;

    logic in_acc;
    logic in_ram1, in_ram2, in_ram;
    logic cur_ram1, cur_ram2;
    logic [RAM_WORD_BITS-1:0] in_w0, cur_w0, cur_w1;
    logic [RAM_WORD_BITS-1:0] ram_addr;
    logic        ram_we, ram1_en, ram2_en;
    logic [15:0] ram_wdata, ram1_rdata, ram2_rdata, cur_rdata;
    logic        ctrl_wr;
    logic        out_load;
    t_out_item   res;

    assign o_in_stall  = (r_state != S_IDLE);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // finished item moves into the output register when it is free or draining
    assign out_load = (r_state == S_FIN) && (!r_out_valid || !i_out_stall);

    // size code 3 never touches RAM
    assign in_ram1 = (i_in_item.bus_address[23:20] == SEL_RAM_ONE) &&
                     (i_in_item.access_size != SIZE_NONE);
    assign in_ram2 = (i_in_item.bus_address[23:20] == SEL_RAM_TWO) &&
                     (i_in_item.access_size != SIZE_NONE);
    assign in_ram  = in_ram1 || in_ram2;

    assign cur_ram1 = (r_item.bus_address[23:20] == SEL_RAM_ONE);
    assign cur_ram2 = (r_item.bus_address[23:20] == SEL_RAM_TWO);

    // word index ignores bit 0; second half of a long wraps inside the RAM
    assign in_w0  = i_in_item.bus_address[RAM_ADDR_BITS-1:1];
    assign cur_w0 = r_item.bus_address[RAM_ADDR_BITS-1:1];
    assign cur_w1 = cur_w0 + RAM_WORD_BITS'(1);

    assign cur_rdata = cur_ram2 ? ram2_rdata : ram1_rdata;

    assign ctrl_wr = i_in_item.opcode && (i_in_item.access_size == SIZE_BYTE) &&
                     (i_in_item.bus_address == CTRL_ADDR);

    // RAM port drive
    always_comb begin
        ram1_en   = 1'b0;
        ram2_en   = 1'b0;
        ram_we    = 1'b0;
        ram_addr  = in_w0;
        ram_wdata = i_in_item.write_value[15:0];
        case (r_state)
            S_CLEAR: begin
                ram1_en   = 1'b1;
                ram2_en   = 1'b1;
                ram_we    = 1'b1;
                ram_addr  = r_clr;
                ram_wdata = '0;
            end
            S_IDLE: begin
                if (in_acc) begin
                    ram1_en = in_ram1;
                    ram2_en = in_ram2;
                    case (i_in_item.access_size)
                        SIZE_WORD: begin
                            ram_we    = i_in_item.opcode;
                            ram_wdata = i_in_item.write_value[15:0];
                        end
                        SIZE_LONG: begin
                            ram_we    = i_in_item.opcode;
                            ram_wdata = i_in_item.write_value[31:16];
                        end
                        default: ram_we = 1'b0;   // byte: read first
                    endcase
                end
            end
            S_RMW: begin
                ram1_en  = cur_ram1;
                ram2_en  = cur_ram2;
                ram_we   = 1'b1;
                ram_addr = cur_w0;
                // even byte address is the high byte
                ram_wdata = r_item.bus_address[0] ?
                            {cur_rdata[15:8], r_item.write_value[7:0]} :
                            {r_item.write_value[7:0], cur_rdata[7:0]};
            end
            S_LONG: begin
                ram1_en   = cur_ram1;
                ram2_en   = cur_ram2;
                ram_we    = r_item.opcode;
                ram_addr  = cur_w1;
                ram_wdata = r_item.write_value[15:0];
            end
            default: ;
        endcase
    end

    // result of the item in the sequencer
    always_comb begin
        logic [31:0] dm;
        dm  = r_item.write_value;
        res = '0;
        case (r_item.access_size)
            SIZE_BYTE: dm = {24'd0, r_item.write_value[7:0]};
            SIZE_WORD: dm = {16'd0, r_item.write_value[15:0]};
            default:   dm = r_item.write_value;
        endcase
        if (r_item.access_size != SIZE_NONE) begin
            case (r_item.bus_address[23:20])
                SEL_RAM_ONE, SEL_RAM_TWO: begin
                    res.target_region = cur_ram2 ? REGION_RAM_TWO : REGION_RAM_ONE;
                    if (!r_item.opcode) begin
                        case (r_item.access_size)
                            SIZE_BYTE: res.read_value = r_item.bus_address[0] ?
                                                        {24'd0, cur_rdata[7:0]} :
                                                        {24'd0, cur_rdata[15:8]};
                            SIZE_WORD: res.read_value = {16'd0, cur_rdata};
                            default:   res.read_value = {r_hi, cur_rdata};
                        endcase
                    end
                end
                SEL_MASTER, SEL_SLAVE: begin
                    res.target_region = (r_item.bus_address[23:20] == SEL_MASTER) ?
                                        REGION_MASTER : REGION_SLAVE;
                    res.ext_request = 1'b1;
                    res.ext_address = r_item.bus_address;
                    res.ext_write   = r_item.opcode;
                    res.ext_size    = r_item.access_size;
                    res.ext_data    = r_item.opcode ? dm : 32'd0;
                end
                SEL_PROG: begin
                    res.target_region = REGION_PROG;
                    if (!r_item.opcode) begin
                        res.ext_request = 1'b1;
                        res.ext_address = r_item.bus_address & PROG_MASK;
                        res.ext_size    = r_item.access_size;
                    end
                end
                default: begin
                    if (r_item.bus_address[23]) begin
                        // banked sample ROM, ROM writes dropped
                        res.target_region = REGION_SAMPLE;
                        if (!r_item.opcode) begin
                            res.ext_request = 1'b1;
                            res.ext_address = (r_item.bus_address & BANK_MASK) +
                                              (r_ctrl[CTRL_BANK_BIT] ? BANK_BASE : 24'd0);
                            res.ext_size    = r_item.access_size;
                        end
                    end else if (r_item.opcode && (r_item.access_size == SIZE_BYTE) &&
                                 (r_item.bus_address == CTRL_ADDR)) begin
                        res.target_region = REGION_CONTROL;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_ctrl      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + RAM_WORD_BITS'(1);
                    if (r_clr == '1) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (in_acc) begin
                        r_item <= i_in_item;
                        if (ctrl_wr) begin
                            r_ctrl <= i_in_item.write_value[7:0];
                        end
                        if (in_ram) begin
                            case (i_in_item.access_size)
                                SIZE_BYTE: r_state <= i_in_item.opcode ? S_RMW : S_FIN;
                                SIZE_LONG: r_state <= S_LONG;
                                default:   r_state <= S_FIN;
                            endcase
                        end else begin
                            r_state <= S_FIN;
                        end
                    end
                end
                S_RMW: begin
                    r_state <= S_FIN;
                end
                S_LONG: begin
                    r_hi    <= cur_rdata;
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (out_load) begin
                        r_out   <= res;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    scbd_ram #(
        .WIDTH (16),
        .DEPTH (RAM_WORDS)
    ) u_ram_one (
        .i_clk   (i_clk),
        .i_en    (ram1_en),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram1_rdata)
    );

    scbd_ram #(
        .WIDTH (16),
        .DEPTH (RAM_WORDS)
    ) u_ram_two (
        .i_clk   (i_clk),
        .i_en    (ram2_en),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram2_rdata)
    );

`ifndef SYNTHESIS
    a_no_result_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !o_out_valid)
        else $error("result valid during clearing pass");

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state != S_IDLE))
        else $error("sequencer idle right after accepting an item");

    a_fin_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_FIN) && r_out_valid && i_out_stall) |=> (r_state == S_FIN))
        else $error("finished item dropped while output stalled");
`endif

endmodule

`default_nettype wire

[tb/testbench.sv]
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import scbd_pkg::*;

    // Bus direction codes for the opcode field
    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // Highest byte offset of one local RAM
    localparam logic [19:0] RAM_TOP = 20'((1 << RAM_ADDR_BITS) - 1);

    // ------------------------------------------------------------------
    // Decode tracker: keeps its own copy of both RAMs and the control byte,
    // works out the result of each accepted access and holds the results
    // still owed by the block, oldest first.
    // ------------------------------------------------------------------
    class decode_tracker;
        // Key is {ram two select, word index}; absent words read as zero.
        logic [15:0] ram_words [logic [RAM_WORD_BITS:0]];
        logic [7:0]  control_byte;
        t_out_item   owed_results [$];
        int          errors;
        int          checked;
        int          ram_hits;
        int          ext_hits;
        int          control_hits;
        int          other_hits;

        function new();
            control_byte = 8'h00;
            errors       = 0;
            checked      = 0;
            ram_hits     = 0;
            ext_hits     = 0;
            control_hits = 0;
            other_hits   = 0;
        endfunction

        function logic [15:0] peek(logic second, logic [RAM_WORD_BITS-1:0] idx);
            if (ram_words.exists({second, idx}))
                return ram_words[{second, idx}];
            return 16'h0000;
        endfunction

        // One RAM access; returns read data (zero for writes).
        function logic [31:0] ram_op(logic second, t_in_item acc, logic [31:0] data);
            logic [RAM_WORD_BITS-1:0] w0;
            logic [RAM_WORD_BITS-1:0] w1;
            logic [15:0]              cur;
            w0  = acc.bus_address[RAM_ADDR_BITS-1:1];
            w1  = w0 + 1'b1;    // second half of a long wraps inside the RAM
            cur = peek(second, w0);
            case (acc.access_size)
                SIZE_BYTE: begin
                    // even byte address is the high byte of the word
                    if (acc.opcode == OP_WRITE) begin
                        if (acc.bus_address[0])
                            cur[7:0] = data[7:0];
                        else
                            cur[15:8] = data[7:0];
                        ram_words[{second, w0}] = cur;
                        return '0;
                    end
                    return acc.bus_address[0] ? {24'd0, cur[7:0]} : {24'd0, cur[15:8]};
                end
                SIZE_WORD: begin
                    if (acc.opcode == OP_WRITE) begin
                        ram_words[{second, w0}] = data[15:0];
                        return '0;
                    end
                    return {16'd0, cur};
                end
                default: begin
                    if (acc.opcode == OP_WRITE) begin
                        ram_words[{second, w0}] = data[31:16];
                        ram_words[{second, w1}] = data[15:0];
                        return '0;
                    end
                    return {cur, peek(second, w1)};
                end
            endcase
        endfunction

        function t_out_item decode_access(t_in_item acc);
            t_out_item   res;
            logic [31:0] data;
            logic [3:0]  sel;
            logic        ext;
            logic [23:0] eaddr;
            res   = '0;
            ext   = 1'b0;
            eaddr = '0;
            if (acc.access_size == SIZE_NONE) begin
                other_hits++;
                return res;
            end
            data = acc.write_value;
            if (acc.access_size == SIZE_BYTE)
                data = {24'd0, data[7:0]};
            else if (acc.access_size == SIZE_WORD)
                data = {16'd0, data[15:0]};
            sel = acc.bus_address[23:20];

            if (sel == SEL_RAM_ONE) begin
                res.target_region = REGION_RAM_ONE;
                res.read_value    = ram_op(1'b0, acc, data);
            end else if (sel == SEL_RAM_TWO) begin
                res.target_region = REGION_RAM_TWO;
                res.read_value    = ram_op(1'b1, acc, data);
            end else if (sel == SEL_MASTER || sel == SEL_SLAVE) begin
                res.target_region = (sel == SEL_MASTER) ? REGION_MASTER : REGION_SLAVE;
                ext   = 1'b1;
                eaddr = acc.bus_address;
            end else if (sel == SEL_PROG) begin
                res.target_region = REGION_PROG;
                ext   = (acc.opcode == OP_READ);
                eaddr = acc.bus_address & PROG_MASK;
            end else if (sel[3]) begin
                // upper half of the map is the banked sample ROM
                res.target_region = REGION_SAMPLE;
                ext   = (acc.opcode == OP_READ);
                eaddr = (acc.bus_address & BANK_MASK) +
                        (control_byte[CTRL_BANK_BIT] ? BANK_BASE : 24'd0);
            end else if (acc.opcode == OP_WRITE && acc.access_size == SIZE_BYTE &&
                         acc.bus_address == CTRL_ADDR) begin
                res.target_region = REGION_CONTROL;
                control_byte      = data[7:0];
            end

            if (acc.opcode == OP_WRITE)
                res.read_value = '0;
            if (ext) begin
                res.read_value  = '0;
                res.ext_request = 1'b1;
                res.ext_address = eaddr;
                res.ext_write   = acc.opcode;
                res.ext_size    = acc.access_size;
                res.ext_data    = (acc.opcode == OP_WRITE) ? data : 32'd0;
            end

            if (ext)
                ext_hits++;
            else if (res.target_region == REGION_RAM_ONE ||
                     res.target_region == REGION_RAM_TWO)
                ram_hits++;
            else if (res.target_region == REGION_CONTROL)
                control_hits++;
            else
                other_hits++;
            return res;
        endfunction

        function void note_access(t_in_item acc);
            owed_results.push_back(decode_access(acc));
        endfunction

        function void compare_field(string field, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                $display("%0t: %s mismatch: expected %h, got %h", $time, field, want, got);
                errors++;
            end
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            if (owed_results.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
                return;
            end
            want = owed_results.pop_front();
            checked++;
            compare_field("read_value",    want.read_value,    got.read_value);
            compare_field("target_region", 32'(want.target_region), 32'(got.target_region));
            compare_field("ext_request",   32'(want.ext_request),   32'(got.ext_request));
            compare_field("ext_address",   32'(want.ext_address),   32'(got.ext_address));
            compare_field("ext_write",     32'(want.ext_write),     32'(got.ext_write));
            compare_field("ext_size",      32'(want.ext_size),      32'(got.ext_size));
            compare_field("ext_data",      want.ext_data,      got.ext_data);
        endfunction

        function int outstanding();
            return owed_results.size();
        endfunction
    endclass

    // ------------------------------------------------------------------
    // Clock, reset and the block
    // ------------------------------------------------------------------
    logic      i_clk     = 1'b0;
    logic      i_rst_n   = 1'b0;
    logic      in_valid  = 1'b0;
    t_in_item  in_item   = '0;
    logic      out_stall = 1'b0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_item o_out_item;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    sound_cpu_bus_decoder uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (o_out_item)
    );

    decode_tracker tracker = new();

    // ------------------------------------------------------------------
    // Result side: the stall pattern switches at random between modes
    // (never, light, heavy, long bursts); results are checked at the
    // rising edge when they are taken.
    // ------------------------------------------------------------------
    int stall_mode  = 0;
    int stall_left  = 0;
    int stall_burst = 0;

    always @(negedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(32, 256);
        end else begin
            stall_left--;
        end
        case (stall_mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 3) == 0);
            2: out_stall <= ($urandom_range(0, 3) != 0);
            default: begin
                if (stall_burst > 0) begin
                    stall_burst--;
                    out_stall <= 1'b1;
                end else if ($urandom_range(0, 7) == 0) begin
                    stall_burst = $urandom_range(1, 20);
                    out_stall <= 1'b1;
                end else begin
                    out_stall <= 1'b0;
                end
            end
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !out_stall)
            tracker.check_result(o_out_item);
    end

    // ------------------------------------------------------------------
    // Access side: bursts of random length, random idle gaps between them
    // (a third of the bursts start with no gap at all).
    // ------------------------------------------------------------------
    int burst_left = 0;
    int items_sent = 0;

    function automatic t_in_item make_access(logic op, logic [1:0] size,
                                             logic [23:0] addr, logic [31:0] data);
        t_in_item acc;
        acc.opcode      = op;
        acc.access_size = size;
        acc.bus_address = addr;
        acc.write_value = data;
        return acc;
    endfunction

    task automatic send_access(input t_in_item acc);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0) begin
                @(negedge i_clk);
                in_valid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
        burst_left--;
        @(negedge i_clk);
        in_valid <= 1'b1;
        in_item  <= acc;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        tracker.note_access(acc);
        items_sent++;
    endtask

    // mostly real sizes, now and then the no-access code
    function automatic logic [1:0] pick_size();
        if ($urandom_range(0, 19) == 0)
            return SIZE_NONE;
        return 2'($urandom_range(0, 2));
    endfunction

    // RAM address that is likely to hit words written earlier: the first or
    // last 32 bytes of the RAM, sometimes anywhere
    function automatic logic [23:0] ram_address(logic [3:0] sel);
        logic [19:0] off;
        case ($urandom_range(0, 4))
            0, 1:    off = 20'($urandom_range(0, 31));
            2, 3:    off = RAM_TOP - 20'($urandom_range(0, 31));
            default: off = 20'($urandom);
        endcase
        return {sel, off};
    endfunction

    task automatic random_scenario();
        int          pick;
        logic [3:0]  sel;
        logic [23:0] addr;
        pick = $urandom_range(0, 99);
        sel  = $urandom_range(0, 1) ? SEL_RAM_TWO : SEL_RAM_ONE;
        if (pick < 35) begin
            // write then read back, sizes drawn independently
            addr = ram_address(sel);
            send_access(make_access(OP_WRITE, pick_size(), addr, $urandom));
            send_access(make_access(OP_READ, pick_size(), addr, $urandom));
        end else if (pick < 50) begin
            send_access(make_access(1'($urandom), pick_size(), ram_address(sel), $urandom));
        end else if (pick < 60) begin
            // control byte write with random bank bit, followed by sample ROM reads
            send_access(make_access(OP_WRITE, SIZE_BYTE, CTRL_ADDR, $urandom));
            repeat ($urandom_range(1, 2))
                send_access(make_access(OP_READ, pick_size(),
                                        {1'b1, 23'($urandom)}, $urandom));
        end else if (pick < 70) begin
            sel = $urandom_range(0, 1) ? SEL_SLAVE : SEL_MASTER;
            send_access(make_access(1'($urandom), pick_size(),
                                    {sel, 20'($urandom)}, $urandom));
        end else if (pick < 78) begin
            send_access(make_access(1'($urandom), pick_size(),
                                    {SEL_PROG, 20'($urandom)}, $urandom));
        end else if (pick < 85) begin
            send_access(make_access(1'($urandom), pick_size(),
                                    {1'b1, 23'($urandom)}, $urandom));
        end else begin
            // noise over the whole map
            send_access(make_access(1'($urandom), 2'($urandom),
                                    24'($urandom), $urandom));
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // RAM one: byte order, odd word address, long wrap at the top
        send_access(make_access(OP_WRITE, SIZE_WORD, 24'h000000, 32'hFFFF1234));
        send_access(make_access(OP_READ,  SIZE_BYTE, 24'h000000, 32'h00000000));
        send_access(make_access(OP_READ,  SIZE_BYTE, 24'h000001, 32'hFFFFFFFF));
        send_access(make_access(OP_WRITE, SIZE_BYTE, 24'h000001, 32'hFFFFFFAB));
        send_access(make_access(OP_READ,  SIZE_WORD, 24'h000001, 32'h00000000));
        send_access(make_access(OP_WRITE, SIZE_LONG, 24'h0FFFFE, 32'hDEADBEEF));
        send_access(make_access(OP_READ,  SIZE_LONG, 24'h0FFFFE, 32'h00000000));
        send_access(make_access(OP_READ,  SIZE_LONG, 24'h000000, 32'h00000000));
        // RAM two: odd long address wraps as well
        send_access(make_access(OP_WRITE, SIZE_LONG, 24'h2FFFFF, 32'hFFFFFFFF));
        send_access(make_access(OP_READ,  SIZE_LONG, 24'h2FFFFC, 32'h00000000));
        send_access(make_access(OP_READ,  SIZE_LONG, 24'h2FFFFE, 32'h00000000));
        // chip registers pass the full address and masked write data
        send_access(make_access(OP_WRITE, SIZE_BYTE, 24'h100000, 32'hFFFFFFFF));
        send_access(make_access(OP_READ,  SIZE_LONG, 24'h3FFFFF, 32'hFFFFFFFF));
        // program ROM: long read at the top, writes ignored
        send_access(make_access(OP_READ,  SIZE_LONG, 24'h6FFFFE, 32'h00000000));
        send_access(make_access(OP_WRITE, SIZE_WORD, 24'h600002, 32'h12345678));
        // sample ROM in both banks
        send_access(make_access(OP_READ,  SIZE_BYTE, 24'h800000, 32'h00000000));
        send_access(make_access(OP_WRITE, SIZE_BYTE, CTRL_ADDR,  32'h00000010));
        send_access(make_access(OP_READ,  SIZE_WORD, 24'hFFFFFF, 32'h00000000));
        send_access(make_access(OP_WRITE, SIZE_LONG, 24'h9ABCDE, 32'hCAFEF00D));
        // control read and wide control write fall through to unmapped
        send_access(make_access(OP_READ,  SIZE_BYTE, CTRL_ADDR,  32'h00000000));
        send_access(make_access(OP_WRITE, SIZE_WORD, CTRL_ADDR,  32'h00000000));
        send_access(make_access(OP_WRITE, SIZE_BYTE, CTRL_ADDR,  32'h000000EF));
        send_access(make_access(OP_READ,  SIZE_LONG, 24'hC00000, 32'h00000000));
        send_access(make_access(OP_READ,  SIZE_LONG, 24'h500000, 32'h00000000));
        // no-access size code must leave the RAM alone
        send_access(make_access(OP_WRITE, SIZE_NONE, 24'h000000, 32'h00000000));
        send_access(make_access(OP_READ,  SIZE_WORD, 24'h000000, 32'h00000000));

        while (items_sent < 625)
            random_scenario();

        @(negedge i_clk);
        in_valid <= 1'b0;

        // drain, then give a late or extra result a chance to show up
        while (tracker.outstanding() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("Covered %0d accesses: %0d local RAM, %0d external, %0d control writes,",
                 items_sent, tracker.ram_hits, tracker.ext_hits, tracker.control_hits);
        $display("%0d ignored or unmapped; %0d results checked, %0d errors.",
                 tracker.other_hits, tracker.checked, tracker.errors);
        if (tracker.errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // RAM clearing pass makes up most of the run, well inside this timeout
    initial begin
        #30_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

`default_nettype wire
